// ===== rtl/core/sfnft_pkg.sv =====
// Shared constants, register codes and color ramp table for the noise floor tracker.
package sfnft_pkg;

  localparam int FrameBinsDef     = 512;
  localparam int HistogramBinsDef = 256;

  localparam int HeightW    = 12;
  localparam int AudioW     = 8;
  localparam int ColorW     = 8;
  localparam int BinW       = 8;
  localparam int StepW      = 2;
  localparam int CntW       = 9;
  localparam int BiasW      = 10;
  localparam int IntensW    = 7;
  localparam int DiffW      = 14;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 10;
  localparam int InTdataW   = 24;
  localparam int OutTdataW  = 32;

  localparam int AudioSpan  = 256;
  localparam int ClipSpan   = 253;
  localparam int IntensMax  = 116;
  localparam int RampSeg    = 51;

  localparam logic [AudioW-1:0] ClipPeakRst      = 8'd118;
  localparam logic [BinW-1:0]   UpperTargetRst   = 8'd30;
  localparam logic [BinW-1:0]   LowerTargetRst   = 8'd28;
  localparam logic [BiasW-1:0]  WaterfallBiasRst = 10'd236;

  localparam logic [StepW-1:0] StepNone = 2'b00;
  localparam logic [StepW-1:0] StepUp   = 2'b01;
  localparam logic [StepW-1:0] StepDown = 2'b11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP_PEAK      = 2'd0,
    CFG_UPPER_TARGET   = 2'd1,
    CFG_LOWER_TARGET   = 2'd2,
    CFG_WATERFALL_BIAS = 2'd3
  } cfg_reg_e;

  typedef logic [IntensMax:0][ColorW-1:0] color_lut_t;

  // Intensity 0..116 -> scaled by 2.2 (floored) -> RGB332 ramp color
  function automatic color_lut_t build_color_lut();
    color_lut_t lut;
    int s;
    int r;
    int g;
    int b;
    for (int i = 0; i <= IntensMax; i++) begin
      s = i * 22 / 10;
      r = 0;
      g = 0;
      b = 0;
      if (s < RampSeg) begin
        b = s * 3 / RampSeg;
      end else if (s < 2 * RampSeg) begin
        b = 3;
        g = (s - RampSeg) * 7 / RampSeg;
      end else if (s < 3 * RampSeg) begin
        b = (RampSeg - (s - 2 * RampSeg)) * 3 / RampSeg;
        g = 7;
      end else if (s < 4 * RampSeg) begin
        g = 7;
        r = (s - 3 * RampSeg) * 7 / RampSeg;
      end else begin
        g = (RampSeg - (s - 4 * RampSeg)) * 7 / RampSeg;
        r = 7;
      end
      lut[i] = ColorW'((r << 5) | (g << 2) | b);
    end
    return lut;
  endfunction

  localparam color_lut_t ColorLut = build_color_lut();

endpackage

// ===== rtl/core/spectrum_frame_noise_floor_tracker.sv =====
// Noise floor tracker: waterfall color, audio clip and per-frame histogram mode.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: spec_height, audio_height
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: color, clipped, floor bin, step;
//                                                tlast: frame_last
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One bin per cycle sustained while m_axis accepts; a bin's result passes the stage 1 and output registers to m_axis.
// Histogram lives in two banks (one per frame, ping-pong); read-modify-write with a
// registered read and forwarding of the write in flight. The idle bank is swept clear
// one entry a cycle during the next frame. After reset both banks are swept, all
// min(HISTOGRAM_BINS,256) entries, before the first item is taken.
// Output stalls back up through one pipeline register into s_axis_tready.
module spectrum_frame_noise_floor_tracker #(
  parameter int FRAME_BINS     = sfnft_pkg::FrameBinsDef,
  parameter int HISTOGRAM_BINS = sfnft_pkg::HistogramBinsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [11:0] spec_height, [19:12] audio_height
  input  logic [sfnft_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] waterfall_color, [15:8] audio_height_clipped,
  // [23:16] noise_floor_bin, [25:24] offset_step
  output logic [sfnft_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // frame_last
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfnft_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfnft_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sfnft_pkg::*;

  localparam int HistDepth = (HISTOGRAM_BINS > AudioSpan) ? AudioSpan : HISTOGRAM_BINS;
  localparam int IdxW      = $clog2(HistDepth);
  localparam int PosW      = $clog2(FRAME_BINS);

  // configuration
  logic [AudioW-1:0] clip_peak_q;
  logic [BinW-1:0]   upper_target_q;
  logic [BinW-1:0]   lower_target_q;
  logic [BiasW-1:0]  waterfall_bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_peak_q      <= ClipPeakRst;
      upper_target_q   <= UpperTargetRst;
      lower_target_q   <= LowerTargetRst;
      waterfall_bias_q <= WaterfallBiasRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CLIP_PEAK:      clip_peak_q      <= cfg_data_i[AudioW-1:0];
        CFG_UPPER_TARGET:   upper_target_q   <= cfg_data_i[BinW-1:0];
        CFG_LOWER_TARGET:   lower_target_q   <= cfg_data_i[BinW-1:0];
        CFG_WATERFALL_BIAS: waterfall_bias_q <= cfg_data_i[BiasW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic            s1_v_q, s1_fire, in_fire, out_v_q;
  logic            clr_busy_q, clr_init_q, bank_q;
  logic [IdxW-1:0] clr_cnt_q;
  logic [PosW-1:0] pos_q;

  // stage 0: decode incoming bin
  logic signed [HeightW-1:0] in_height;
  logic [AudioW-1:0]         in_audio, in_clip;
  logic [IdxW-1:0]           in_idx;
  logic                      in_upd, in_last;
  logic signed [DiffW-1:0]   in_diff;
  logic [IntensW-1:0]        in_inten;

  assign in_height = $signed(s_axis_tdata[HeightW-1:0]);
  assign in_audio  = s_axis_tdata[HeightW +: AudioW];

  always_comb begin
    if (32'(in_audio) >= 32'(HistDepth)) begin
      in_idx = IdxW'(HistDepth - 1);
    end else begin
      in_idx = in_audio[IdxW-1:0];
    end
    in_upd  = (32'(pos_q) < 32'(AudioSpan)) && (in_audio != '0);
    in_last = (pos_q == PosW'(FRAME_BINS - 1));
    if ((32'(pos_q) < 32'(ClipSpan)) && (in_audio != '0) && (in_audio > clip_peak_q)) begin
      in_clip = clip_peak_q;
    end else begin
      in_clip = in_audio;
    end
    in_diff = $signed({{(DiffW-BiasW){1'b0}}, waterfall_bias_q})
            - $signed({{(DiffW-HeightW){in_height[HeightW-1]}}, in_height});
    if (in_diff < 0) begin
      in_inten = '0;
    end else if (in_diff > DiffW'(IntensMax)) begin
      in_inten = IntensW'(IntensMax);
    end else begin
      in_inten = in_diff[IntensW-1:0];
    end
  end

  assign s1_fire       = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q || !clr_init_q ? (!s1_v_q || s1_fire) : 1'b0;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // stage 1 registers
  logic               s1_bank_q, s1_upd_q, s1_last_q;
  logic [IdxW-1:0]    s1_idx_q;
  logic [IntensW-1:0] s1_inten_q;
  logic [AudioW-1:0]  s1_clip_q;
  logic               fwd_hit_q;
  logic [CntW-1:0]    fwd_val_q;
  logic [CntW-1:0]    rd0_q, rd1_q;

  logic [CntW-1:0] s1_base, s1_cnt, best_count_q;
  logic [BinW-1:0] best_bin_q, s1_best_bin;
  logic            s1_better, s1_we;
  logic [StepW-1:0] s1_step;

  always_comb begin
    s1_base     = fwd_hit_q ? fwd_val_q : (s1_bank_q ? rd1_q : rd0_q);
    s1_cnt      = s1_base + CntW'(1);
    s1_better   = s1_upd_q && (s1_cnt > best_count_q);
    s1_best_bin = s1_better ? BinW'(s1_idx_q) : best_bin_q;
    // last bin's count is never read again; its bank is being swept
    s1_we       = s1_fire && s1_upd_q && !s1_last_q;
    if ((s1_best_bin > upper_target_q) && !(s1_best_bin < lower_target_q)) begin
      s1_step = StepDown;
    end else if ((s1_best_bin < lower_target_q) && !(s1_best_bin > upper_target_q)) begin
      s1_step = StepUp;
    end else begin
      s1_step = StepNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      pos_q        <= '0;
      bank_q       <= 1'b0;
      best_count_q <= '0;
      best_bin_q   <= '0;
      clr_busy_q   <= 1'b1;
      clr_init_q   <= 1'b1;
      clr_cnt_q    <= '0;
      fwd_hit_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last_q) begin
          best_count_q <= '0;
          best_bin_q   <= '0;
        end else if (s1_better) begin
          best_count_q <= s1_cnt;
          best_bin_q   <= BinW'(s1_idx_q);
        end
      end
      if (in_fire) begin
        fwd_hit_q <= s1_we && (s1_bank_q == bank_q) && (s1_idx_q == in_idx);
      end
      // a new sweep starts on the last bin, even on the cycle the previous one ends
      if (in_fire && in_last) begin
        clr_busy_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else if (clr_busy_q) begin
        if (clr_cnt_q == IdxW'(HistDepth - 1)) begin
          clr_busy_q <= 1'b0;
          clr_init_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + IdxW'(1);
        end
      end
      if (in_fire) begin
        if (in_last) begin
          pos_q  <= '0;
          bank_q <= !bank_q;
        end else begin
          pos_q <= pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bank_q  <= bank_q;
      s1_upd_q   <= in_upd;
      s1_last_q  <= in_last;
      s1_idx_q   <= in_idx;
      s1_inten_q <= in_inten;
      s1_clip_q  <= in_clip;
    end
    if (s1_we) begin
      fwd_val_q <= s1_cnt;
    end
  end

  // histogram banks
  logic [CntW-1:0] hist0_mem [HistDepth];
  logic [CntW-1:0] hist1_mem [HistDepth];
  logic            clr0, clr1;

  assign clr0 = clr_busy_q && (clr_init_q || bank_q);
  assign clr1 = clr_busy_q && (clr_init_q || !bank_q);

  always_ff @(posedge clk_i) begin
    if (clr0) begin
      hist0_mem[clr_cnt_q] <= '0;
    end else if (s1_we && !s1_bank_q) begin
      hist0_mem[s1_idx_q] <= s1_cnt;
    end
    if (in_fire) begin
      rd0_q <= hist0_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr1) begin
      hist1_mem[clr_cnt_q] <= '0;
    end else if (s1_we && s1_bank_q) begin
      hist1_mem[s1_idx_q] <= s1_cnt;
    end
    if (in_fire) begin
      rd1_q <= hist1_mem[in_idx];
    end
  end

  // output register
  logic [ColorW-1:0] out_color_q;
  logic [AudioW-1:0] out_clip_q;
  logic [BinW-1:0]   out_bin_q;
  logic [StepW-1:0]  out_step_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_color_q <= ColorLut[s1_inten_q];
      out_clip_q  <= s1_clip_q;
      out_last_q  <= s1_last_q;
      out_bin_q   <= s1_last_q ? s1_best_bin : '0;
      out_step_q  <= s1_last_q ? s1_step : StepNone;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutTdataW - StepW - BinW - AudioW - ColorW){1'b0}},
                          out_step_q, out_bin_q, out_clip_q, out_color_q};

endmodule

// ===== test/tb_spectrum_frame_noise_floor_tracker.sv =====
// Self-checking testbench for the noise floor tracker: directed and random frames.
`timescale 1ns / 100ps

module tb_spectrum_frame_noise_floor_tracker;
  import sfnft_pkg::*;

  localparam int SegLen    = 51;
  localparam int HistDepth = 256;
  localparam int MaxPrints = 50;

  typedef struct packed {
    logic signed [11:0] height;
    logic [7:0]         audio;
  } bin_item_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] clipped;
    logic       last;
    logic [7:0] floor_bin;
    logic [1:0] step;
  } bin_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  spectrum_frame_noise_floor_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // register shadows
  logic [7:0] clip_peak_q   = ClipPeakRst;
  logic [7:0] upper_tgt_q   = UpperTargetRst;
  logic [7:0] lower_tgt_q   = LowerTargetRst;
  logic [9:0] wf_bias_q     = WaterfallBiasRst;

  // frame state of the predictor
  logic [8:0] hist_count [HistDepth];
  int         frame_pos = 0;
  logic [8:0] best_count = '0;
  logic [7:0] best_bin = '0;

  bin_item_t   bin_queue [$];
  bin_result_t expected_bins [$];
  bin_item_t   bin_on_bus;
  logic        s_fire = 1'b0;
  logic        no_idle = 1'b0;
  int          mismatches = 0;
  int          result_idx = 0;

  initial begin
    for (int i = 0; i < HistDepth; i++) hist_count[i] = '0;
  end

  function automatic logic [7:0] ramp_rgb(int s);
    int r;
    int g;
    int b;
    r = 0;
    g = 0;
    b = 0;
    if (s < SegLen) begin
      b = s * 3 / SegLen;
    end else if (s < 2 * SegLen) begin
      b = 3;
      g = (s - SegLen) * 7 / SegLen;
    end else if (s < 3 * SegLen) begin
      b = (3 * SegLen - s) * 3 / SegLen;
      g = 7;
    end else if (s < 4 * SegLen) begin
      g = 7;
      r = (s - 3 * SegLen) * 7 / SegLen;
    end else begin
      g = (5 * SegLen - s) * 7 / SegLen;
      r = 7;
    end
    return 8'((r << 5) | (g << 2) | b);
  endfunction

  function automatic bin_result_t track_bin(bin_item_t it);
    bin_result_t res;
    logic [8:0]  cnt;
    int          inten;
    res = '0;
    if (frame_pos < AudioSpan && it.audio != 8'd0) begin
      cnt = hist_count[it.audio] + 9'd1;
      hist_count[it.audio] = cnt;
      // mode only moves on a strictly greater count
      if (cnt > best_count) begin
        best_count = cnt;
        best_bin = it.audio;
      end
    end
    res.clipped = (frame_pos < ClipSpan && it.audio > clip_peak_q) ? clip_peak_q : it.audio;
    inten = int'(wf_bias_q) - int'(it.height);
    if (inten < 0) inten = 0;
    if (inten > IntensMax) inten = IntensMax;
    res.color = ramp_rgb(inten * 22 / 10);
    if (frame_pos == FrameBinsDef - 1) begin
      res.last = 1'b1;
      res.floor_bin = best_bin;
      if (best_bin > upper_tgt_q && best_bin < lower_tgt_q) res.step = StepNone;
      else if (best_bin > upper_tgt_q) res.step = StepDown;
      else if (best_bin < lower_tgt_q) res.step = StepUp;
      else res.step = StepNone;
      for (int i = 0; i < HistDepth; i++) hist_count[i] = '0;
      best_count = '0;
      best_bin = '0;
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MaxPrints)
      $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h", result_idx, what, got, want);
    mismatches++;
  endtask

  task automatic push_bin(int h, int a);
    bin_item_t it;
    it.height = 12'(h);
    it.audio = 8'(a);
    bin_queue.push_back(it);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CLIP_PEAK:      clip_peak_q = val[7:0];
      CFG_UPPER_TARGET:   upper_tgt_q = val[7:0];
      CFG_LOWER_TARGET:   lower_tgt_q = val[7:0];
      CFG_WATERFALL_BIAS: wf_bias_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (bin_queue.size() != 0 || s_axis_tvalid || expected_bins.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sender and receiver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || s_fire) begin
      if (rst_ni && bin_queue.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
        bin_on_bus = bin_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, bin_on_bus.audio, bin_on_bus.height};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= no_idle || $urandom_range(99) >= 8;
  end

  always @(posedge clk_i) begin
    bin_result_t want;
    s_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (s_fire) expected_bins.push_back(track_bin(bin_on_bus));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = expected_bins.pop_front();
        if (m_axis_tdata[7:0] != want.color)
          report_mismatch("waterfall_color", 32'(m_axis_tdata[7:0]), 32'(want.color));
        if (m_axis_tdata[15:8] != want.clipped)
          report_mismatch("audio_height_clipped", 32'(m_axis_tdata[15:8]), 32'(want.clipped));
        if (m_axis_tlast != want.last)
          report_mismatch("frame_last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tdata[23:16] != want.floor_bin)
          report_mismatch("noise_floor_bin", 32'(m_axis_tdata[23:16]), 32'(want.floor_bin));
        if (m_axis_tdata[25:24] != want.step)
          report_mismatch("offset_step", 32'(m_axis_tdata[25:24]), 32'(want.step));
      end
      result_idx++;
    end
  end

  initial begin
    int dir_h [17] = '{-2048, 2047, -1, 0, 236, 235, 213, 212, 190, 189, 167, 166,
                       144, 143, 121, 120, 119};
    int dir_a [17] = '{0, 255, 118, 119, 117, 1, 128, 254, 0, 119, 119, 2,
                       200, 118, 255, 0, 127};
    // per frame: dominant audio value and targets for the frame end
    int dom_audio [4] = '{200, 0, 100, 10};
    int upper_goal [4] = '{30, 255, 20, 255};
    int lower_goal [4] = '{28, 0, 200, 28};
    int pos;
    int seg;
    int a;
    int h;
    logic [9:0] v;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ramp breakpoints and clamp edges at the reset bias, clip edges at the reset peak
    for (int i = 0; i < 17; i++) push_bin(dir_h[i], dir_a[i]);

    for (int f = 0; f < 4; f++) begin
      pos = (f == 0) ? 17 : 0;
      no_idle = (f == 2);
      while (pos < FrameBinsDef) begin
        wait_drained();
        if (FrameBinsDef - pos <= 300) begin
          seg = FrameBinsDef - pos;
          write_reg(CFG_UPPER_TARGET, 10'(upper_goal[f]));
          write_reg(CFG_LOWER_TARGET, 10'(lower_goal[f]));
        end else begin
          seg = $urandom_range(60, 250);
          for (int k = 0; k < 4; k++) begin
            if ($urandom_range(9) < 4) begin
              case ($urandom_range(3))
                0: v = 10'd0;
                1: v = (k == 3) ? 10'h3FF : 10'h0FF;
                default: v = 10'($urandom);
              endcase
              // bits above an 8-bit register must be dropped
              if (k != 3) v[9:8] = 2'($urandom);
              write_reg(cfg_reg_e'(k), v);
            end
          end
          if (pos == 0 && f == 1) write_reg(CFG_WATERFALL_BIAS, 10'h3FF);
          if (pos == 0 && f == 2) begin
            write_reg(CFG_CLIP_PEAK, 10'h0FF);
            write_reg(CFG_WATERFALL_BIAS, 10'd0);
          end
          if (pos == 0 && f == 3) write_reg(CFG_CLIP_PEAK, 10'd0);
        end
        for (int p = pos; p < pos + seg; p++) begin
          if (f == 1 && p < AudioSpan) a = 0;  // frame with an empty histogram
          else if ($urandom_range(99) < 15) a = 0;
          else if ($urandom_range(99) < 45) a = dom_audio[f];
          else a = $urandom_range(255);
          if ($urandom_range(9) < 3) h = $urandom_range(4095);
          else h = int'(wf_bias_q) - ($urandom_range(131) - 5);
          push_bin(h, a);
        end
        pos += seg;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
